[rtl/core/ubxfe_pkg.sv]
// Shared types and constants of the UBX frame encoder.
`default_nettype none
package ubxfe_pkg;

  // Sync characters and the opcode of an input item.
  localparam logic [7:0] SYNC_CHAR_1 = 8'hb5;
  localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
  localparam logic       OP_START    = 1'b0;
  localparam logic       OP_DATA     = 1'b1;

  // Highest step index of each job shape.
  localparam logic [2:0] STEP_HDR_LAST     = 3'd5;
  localparam logic [2:0] STEP_HDR_CK_LAST  = 3'd7;
  localparam logic [2:0] STEP_DATA_LAST    = 3'd0;
  localparam logic [2:0] STEP_DATA_CK_LAST = 3'd2;

  // Kind of work the back end carries out for one item.
  typedef enum logic [1:0] {
    JOB_START,
    JOB_DATA,
    JOB_STRAY
  } job_kind_t;

  // One classified item, ready to be expanded into output bytes.
  // For a start item b0..b3 are class, id, length low and length high;
  // for a payload item b0 is the payload byte.
  typedef struct packed {
    job_kind_t  kind;
    logic       cksum;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
  } job_t;

endpackage
`default_nettype wire

[rtl/core/ubxfe_front.sv]
// Front end: frame state, Fletcher sums and classification of input items.
`default_nettype none
module ubxfe_front
  import ubxfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic        opcode,
  input  wire logic [7:0]  msg_class,
  input  wire logic [7:0]  msg_id,
  input  wire logic [15:0] payload_length,
  input  wire logic [7:0]  payload_byte,
  output job_t             job,
  output logic             job_push
);

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;

  logic [7:0]  a1, a2, a3, a4, s1, s2, s3, s4;
  logic [7:0]  pa, pb;
  logic [15:0] left_dec;

  // Header sums (four chained byte adds from zero) and payload sums.
  always_comb begin
    a1 = msg_class;
    s1 = msg_class;
    a2 = a1 + msg_id;
    s2 = s1 + a2;
    a3 = a2 + payload_length[7:0];
    s3 = s2 + a3;
    a4 = a3 + payload_length[15:8];
    s4 = s3 + a4;
    pa = sum_a_r + payload_byte;
    pb = sum_b_r + pa;
    left_dec = bytes_left_r - 16'd1;
  end

  // Classify the item and work out the state that it leaves.
  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    job.kind       = JOB_STRAY;
    job.cksum      = 1'b0;
    job.b0         = msg_class;
    job.b1         = msg_id;
    job.b2         = payload_length[7:0];
    job.b3         = payload_length[15:8];
    job.sum_a      = a4;
    job.sum_b      = s4;
    if (opcode == OP_START) begin
      job.kind       = JOB_START;
      job.cksum      = (payload_length == 16'd0);
      sum_a_nxt      = a4;
      sum_b_nxt      = s4;
      frame_open_nxt = (payload_length != 16'd0);
      bytes_left_nxt = payload_length;
    end else if (frame_open_r) begin
      job.kind       = JOB_DATA;
      job.b0         = payload_byte;
      job.cksum      = (left_dec == 16'd0);
      job.sum_a      = pa;
      job.sum_b      = pb;
      sum_a_nxt      = pa;
      sum_b_nxt      = pb;
      bytes_left_nxt = left_dec;
      frame_open_nxt = (left_dec != 16'd0);
    end
  end

  assign job_push = acc;

  // State registers, updated on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
    end else if (acc) begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An open frame always has payload bytes still to come.
  a_open_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> (bytes_left_r != 16'd0))
    else $error("open frame with no bytes left");

  // A closed frame keeps no byte count.
  a_closed_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> (bytes_left_r == 16'd0))
    else $error("closed frame with bytes left");
`endif

endmodule
`default_nettype wire

[rtl/core/ubxfe_queue.sv]
// Short job queue between the front end and the back end.
`default_nettype none
module ubxfe_queue
  import ubxfe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  job_t      wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = slots_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never runs past the depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");

  // Head and tail pointers meet only when the queue is empty or full.
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (count_r == '0 || count_r == CW'(DEPTH)))
    else $error("queue pointers out of step with count");
`endif

endmodule
`default_nettype wire

[rtl/core/ubxfe_back.sv]
// Back end: expands each job into output bytes behind an output register.
`default_nettype none
module ubxfe_back
  import ubxfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic             out_end_of_frame,
  output logic             out_stray_byte
);

  logic [2:0] step_r, step_nxt;
  logic [2:0] last_step;
  logic       load;
  logic       at_last;
  logic [7:0] res_byte;
  logic       res_stray;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, eof_r, stray_r;

  // Last step of the job at the queue head.
  always_comb begin
    case (q_job.kind)
      JOB_START: last_step = q_job.cksum ? STEP_HDR_CK_LAST : STEP_HDR_LAST;
      JOB_DATA:  last_step = q_job.cksum ? STEP_DATA_CK_LAST : STEP_DATA_LAST;
      JOB_STRAY: last_step = STEP_DATA_LAST;
      default:   last_step = STEP_DATA_LAST;
    endcase
  end

  // Byte produced at the current step.
  always_comb begin
    res_stray = 1'b0;
    res_byte  = 8'h00;
    case (q_job.kind)
      JOB_START: begin
        case (step_r)
          3'd0:    res_byte = SYNC_CHAR_1;
          3'd1:    res_byte = SYNC_CHAR_2;
          3'd2:    res_byte = q_job.b0;
          3'd3:    res_byte = q_job.b1;
          3'd4:    res_byte = q_job.b2;
          3'd5:    res_byte = q_job.b3;
          3'd6:    res_byte = q_job.sum_a;
          default: res_byte = q_job.sum_b;
        endcase
      end
      JOB_DATA: begin
        case (step_r)
          3'd0:    res_byte = q_job.b0;
          3'd1:    res_byte = q_job.sum_a;
          default: res_byte = q_job.sum_b;
        endcase
      end
      JOB_STRAY: res_stray = 1'b1;
      default:   res_stray = 1'b1;
    endcase
  end

  // Advance one step whenever the output register can take a result.
  assign load     = q_valid && (!valid_r || pop);
  assign at_last  = (step_r == last_step);
  assign q_pop    = load && at_last;
  assign step_nxt = at_last ? 3'd0 : step_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= step_nxt;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= res_byte;
      last_r  <= at_last;
      eof_r   <= at_last && q_job.cksum && (q_job.kind != JOB_STRAY);
      stray_r <= res_stray;
    end
  end

  assign empty            = !valid_r;
  assign out_byte         = byte_r;
  assign out_last_of_run  = last_r;
  assign out_end_of_frame = eof_r;
  assign out_stray_byte   = stray_r;

`ifndef NO_ASSERTIONS
  // The step counter never passes the end of the job at the head.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (step_r <= last_step))
    else $error("step beyond end of job");

  // A job leaves the queue only while no step of it is pending.
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (step_r == 3'd0))
    else $error("step counter left mid-job");
`endif

endmodule
`default_nettype wire

[rtl/core/ubx_frame_encoder_unit.sv]
// Top level of the UBX frame encoder with Fletcher-8 checksum.
//
//   channel  direction  handshake      fields
//   input    in         push / full    in_opcode, in_msg_class, in_msg_id,
//                                      in_payload_length, in_payload_byte
//   result   out        empty / pop    out_byte, out_last_of_run,
//                                      out_end_of_frame, out_stray_byte
//
// One output byte leaves per cycle while jobs are queued and pop is held high.
// A stray or mid-frame payload item yields one byte, the last payload byte of a
// frame three, and a start item six or eight; the back end's step counter sets
// that figure. An accepted item is written into the job queue and, with the
// output free, its first byte is then loaded into the output register, which
// makes empty fall. Reset is synchronous; it empties the queue and closes any
// open frame. A stalled output fills the job queue, and full rises only when all
// QUEUE_DEPTH entries hold jobs.
`default_nettype none
module ubx_frame_encoder_unit
  import ubxfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_msg_class,
  input  wire logic [7:0]  in_msg_id,
  input  wire logic [15:0] in_payload_length,
  input  wire logic [7:0]  in_payload_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic             out_end_of_frame,
  output logic             out_stray_byte
);

  job_t front_job, head_job;
  logic front_push, head_valid, head_pop, acc;

  assign acc = push && !full;

  // Front end: classify the item and update frame state.
  ubxfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .opcode         (in_opcode),
    .msg_class      (in_msg_class),
    .msg_id         (in_msg_id),
    .payload_length (in_payload_length),
    .payload_byte   (in_payload_byte),
    .job            (front_job),
    .job_push       (front_push)
  );

  // Job queue between the two halves.
  ubxfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_push),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (head_pop),
    .rd_job   (head_job),
    .rd_valid (head_valid)
  );

  // Back end: emit the bytes of each job.
  ubxfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (head_valid),
    .q_job            (head_job),
    .q_pop            (head_pop),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .out_stray_byte   (out_stray_byte)
  );

endmodule
`default_nettype wire

[tb/sv/ubx_frame_encoder_unit_tb.sv]
// Self-checking testbench for the UBX frame encoder: stimulus, byte predictor and checker.
module ubx_frame_encoder_unit_tb;
  import ubxfe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int LONG_HOLD      = 200;

  // One predicted output byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
    logic       stray;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_opcode = OP_START;
  logic [7:0]  in_msg_class = 8'h00;
  logic [7:0]  in_msg_id = 8'h00;
  logic [15:0] in_payload_length = 16'h0000;
  logic [7:0]  in_payload_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_end_of_frame;
  logic        out_stray_byte;

  // Encoder state as the predictor sees it.
  logic        in_frame = 1'b0;
  logic [15:0] bytes_to_go = 16'h0000;
  logic [7:0]  fletcher_a = 8'h00;
  logic [7:0]  fletcher_b = 8'h00;
  enc_byte_t   expected_bytes[$];

  int mismatches = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int strays_seen = 0;
  int full_cycles = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_serial = 0;
  int hold_seen = 0;
  int hold_left = 0;

  ubx_frame_encoder_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_opcode         (in_opcode),
    .in_msg_class      (in_msg_class),
    .in_msg_id         (in_msg_id),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_frame  (out_end_of_frame),
    .out_stray_byte    (out_stray_byte)
  );

  always #1 clk = ~clk;

  // Fold one byte into both running Fletcher sums.
  function automatic void fletcher_add(input logic [7:0] b);
    fletcher_a = fletcher_a + b;
    fletcher_b = fletcher_b + fletcher_a;
  endfunction

  // Work out the bytes that one accepted item produces and queue them.
  task automatic encode_item(input logic op, input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input logic [7:0] pb);
    enc_byte_t run[$];
    enc_byte_t e;
    logic      close_frame;
    close_frame = 1'b0;
    if (op == OP_START) begin
      fletcher_a = 8'h00;
      fletcher_b = 8'h00;
      fletcher_add(cls);
      fletcher_add(id);
      fletcher_add(len[7:0]);
      fletcher_add(len[15:8]);
      run.push_back('{SYNC_CHAR_1, 1'b0, 1'b0, 1'b0});
      run.push_back('{SYNC_CHAR_2, 1'b0, 1'b0, 1'b0});
      run.push_back('{cls, 1'b0, 1'b0, 1'b0});
      run.push_back('{id, 1'b0, 1'b0, 1'b0});
      run.push_back('{len[7:0], 1'b0, 1'b0, 1'b0});
      run.push_back('{len[15:8], 1'b0, 1'b0, 1'b0});
      if (len == 16'h0000) begin
        close_frame = 1'b1;
      end else begin
        in_frame = 1'b1;
        bytes_to_go = len;
      end
    end else if (!in_frame) begin
      // A payload byte outside a frame is dropped and flagged.
      run.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
    end else begin
      fletcher_add(pb);
      run.push_back('{pb, 1'b0, 1'b0, 1'b0});
      bytes_to_go = bytes_to_go - 16'd1;
      if (bytes_to_go == 16'h0000) close_frame = 1'b1;
    end
    if (close_frame) begin
      run.push_back('{fletcher_a, 1'b0, 1'b0, 1'b0});
      run.push_back('{fletcher_b, 1'b0, 1'b1, 1'b0});
      in_frame = 1'b0;
      bytes_to_go = 16'h0000;
    end
    foreach (run[i]) begin
      e = run[i];
      e.last = (i == run.size() - 1);
      expected_bytes.push_back(e);
    end
  endtask

  // Offer one item, wait until it is taken, then predict its bytes.
  // Push is left high so that back-to-back items need no extra assignment.
  task automatic send_item(input logic op, input logic [7:0] cls, input logic [7:0] id,
                           input logic [15:0] len, input logic [7:0] pb);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    in_opcode <= op;
    in_msg_class <= cls;
    in_msg_id <= id;
    in_payload_length <= len;
    in_payload_byte <= pb;
    do @(posedge clk); while (full);
    items_sent++;
    encode_item(op, cls, id, len, pb);
  endtask

  // Start item; the unused payload byte carries noise.
  task automatic send_start(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len);
    send_item(OP_START, cls, id, len, 8'($urandom_range(255)));
  endtask

  // Payload item; the unused header fields carry noise.
  task automatic send_data(input logic [7:0] pb);
    send_item(OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(65535)), pb);
  endtask

  // Start a frame and send the given number of random payload bytes.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int n_bytes);
    send_start(cls, id, len);
    repeat (n_bytes) send_data(8'($urandom_range(255)));
  endtask

  // Drop push and wait until every predicted byte is out.
  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // Empty frames, one-byte and short frames with extreme field values.
  task automatic test_field_extremes();
    send_start(8'h00, 8'h00, 16'h0000);
    send_start(8'hff, 8'hff, 16'h0000);
    send_start(8'hff, 8'h00, 16'h0001);
    send_data(8'hff);
    send_start(8'h00, 8'hff, 16'h0003);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'ha5);
    wait_for_drain();
  endtask

  // Stray bytes and frames cut short by a new start.
  task automatic test_abandon_and_stray();
    send_data(8'h00);
    send_data(8'hff);
    send_start(8'h06, 8'h01, 16'hffff);
    send_data(8'h01);
    send_data(8'h02);
    send_start(8'h0a, 8'h04, 16'h0002);
    send_data(8'h80);
    send_data(8'h7f);
    send_start(8'h01, 8'h02, 16'h8000);
    send_start(8'h05, 8'h09, 16'h0000);
    send_data(8'h55);
    wait_for_drain();
  endtask

  // Mostly well-formed frames with random content, some noise and cut-off frames.
  task automatic test_random_traffic(input int n_items);
    int goal;
    int pick;
    int len;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_data(8'($urandom_range(255)));
      end else if (pick < 18) begin
        len = $urandom_range(65535, 8);
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len),
                   $urandom_range(6));
      end else begin
        if (pick < 78) len = $urandom_range(4);
        else if (pick < 95) len = $urandom_range(20, 5);
        else len = $urandom_range(48, 21);
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len), len);
      end
    end
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while frames keep coming, so full must rise.
  task automatic test_output_stall();
    hold_request = LONG_HOLD;
    hold_serial++;
    repeat (6) send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd3, 3);
    wait_for_drain();
  endtask

  // Receiver: random pops, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_serial != hold_seen) begin
      hold_seen = hold_serial;
      hold_left = hold_request;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // Checker: every accepted byte against the oldest prediction.
  always @(posedge clk) begin : check_output
    enc_byte_t want_b;
    if (rst_n && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual %h last %b eof %b stray %b",
                 $time, out_byte, out_last_of_run, out_end_of_frame, out_stray_byte);
      end else begin
        want_b = expected_bytes.pop_front();
        compare_field("out_byte", want_b.data, out_byte);
        compare_field("out_last_of_run", 8'(want_b.last), 8'(out_last_of_run));
        compare_field("out_end_of_frame", 8'(want_b.eof), 8'(out_end_of_frame));
        compare_field("out_stray_byte", 8'(want_b.stray), 8'(out_stray_byte));
        bytes_checked++;
        if (out_end_of_frame) frames_closed++;
        if (out_stray_byte) strays_seen++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (push && full) full_cycles++;
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_abandon_and_stray();
    test_output_stall();

    send_idle_pct = 18;
    recv_idle_pct = 45;
    test_random_traffic(90);
    send_idle_pct = 45;
    recv_idle_pct = 18;
    test_random_traffic(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(90);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted bytes never arrived", $time, expected_bytes.size());
    end
    $display("Sent %0d items (frames, cut-off frames, stray bytes); checked %0d bytes,",
             items_sent, bytes_checked);
    $display("%0d closed frames, %0d stray flags; input held off by full for %0d cycles.",
             frames_closed, strays_seen, full_cycles);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
